/* src/gpio_controller_with_interrupts_defines.svh */
// Assertion macros for the GPIO controller.
`ifndef GPIO_CONTROLLER_WITH_INTERRUPTS_DEFINES_SVH
`define GPIO_CONTROLLER_WITH_INTERRUPTS_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check that prop holds at every clock edge out of reset.
`define GPIOC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Check that cond at one edge is followed by nxt at the next edge.
`define GPIOC_ASSERT_NEXT(label, cond, nxt, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (nxt)) \
		else $error(msg);
`else
`define GPIOC_ASSERT(label, prop, msg)
`define GPIOC_ASSERT_NEXT(label, cond, nxt, msg)
`endif

`endif

/* src/gpioc_pkg.sv */
package gpioc_pkg;

	localparam int PIN_W     = 25;
	localparam int WORD_W    = 32;
	localparam int NUM_PINS  = 25;
	localparam int LOW_PINS  = 16;

	localparam logic [1:0] FUNC_READ   = 2'd0;
	localparam logic [1:0] FUNC_WRITE  = 2'd1;
	localparam logic [1:0] FUNC_SAMPLE = 2'd2;

	localparam logic [3:0] REG_VALUE     = 4'd0;
	localparam logic [3:0] REG_OUTPUT    = 4'd1;
	localparam logic [3:0] REG_DIRECTION = 4'd2;
	localparam logic [3:0] REG_ENABLE    = 4'd8;
	localparam logic [3:0] REG_RAW       = 4'd9;
	localparam logic [3:0] REG_STATUS    = 4'd10;
	localparam logic [3:0] REG_POLARITY  = 4'd11;
	localparam logic [3:0] REG_TYPE      = 4'd12;

	typedef struct packed {
		logic [1:0]        func;
		logic [3:0]        reg_index;
		logic [WORD_W-1:0] write_data;
		logic [PIN_W-1:0]  pin_levels;
	} gpio_in_t;

	typedef struct packed {
		logic [WORD_W-1:0] read_data;
		logic [PIN_W-1:0]  pin_drive;
		logic [PIN_W-1:0]  pin_output_enable;
		logic              irq;
	} gpio_out_t;

endpackage

/* src/gpioc_core.sv */
module gpioc_core
	import gpioc_pkg::*;
#(
	parameter int NUM_PINS = gpioc_pkg::NUM_PINS,
	parameter int LOW_PINS = gpioc_pkg::LOW_PINS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  gpio_in_t  item,
	output gpio_out_t result
);

	localparam logic [WORD_W-1:0] PinMask32 = WORD_W'((64'd1 << NUM_PINS) - 64'd1);
	localparam logic [WORD_W-1:0] LowMask32 = WORD_W'((64'd1 << LOW_PINS) - 64'd1);
	localparam int                HighShift = WORD_W - NUM_PINS;
	localparam logic [WORD_W-1:0] IntMask   =
		(PinMask32 & LowMask32) | ((PinMask32 & ~LowMask32) << HighShift);
	localparam logic [PIN_W-1:0]  PinMask   = PinMask32[PIN_W-1:0];

	function automatic logic [WORD_W-1:0] spread(input logic [PIN_W-1:0] p);
		logic [WORD_W-1:0] w;
		w = WORD_W'(p) & PinMask32;
		return (w & LowMask32) | ((w & ~LowMask32) << HighShift);
	endfunction

	logic [PIN_W-1:0]  output_q, direction_q, sampled_q;
	logic [WORD_W-1:0] enable_q, raw_q, polarity_q, type_q, prev_active_q;

	logic [PIN_W-1:0]  output_d, direction_d, sampled_d, value_cur, value_d;
	logic [WORD_W-1:0] enable_d, raw_w, raw_d, polarity_d, type_d;
	logic [WORD_W-1:0] active, edges, rdata;

	assign value_cur = ((output_q & direction_q) | (sampled_q & ~direction_q)) & PinMask;

	always_comb begin
		rdata       = '0;
		output_d    = output_q;
		direction_d = direction_q;
		sampled_d   = sampled_q;
		enable_d    = enable_q;
		raw_w       = raw_q;
		polarity_d  = polarity_q;
		type_d      = type_q;
		case (item.func)
			FUNC_READ: begin
				case (item.reg_index)
					REG_VALUE:     rdata = WORD_W'(value_cur);
					REG_OUTPUT:    rdata = WORD_W'(output_q);
					REG_DIRECTION: rdata = WORD_W'(direction_q);
					REG_ENABLE:    rdata = enable_q;
					REG_RAW:       rdata = raw_q;
					REG_STATUS:    rdata = raw_q & enable_q;
					REG_POLARITY:  rdata = polarity_q;
					REG_TYPE:      rdata = type_q;
					default:       rdata = '0;
				endcase
			end
			FUNC_WRITE: begin
				case (item.reg_index)
					REG_OUTPUT:    output_d    = item.write_data[PIN_W-1:0] & PinMask;
					REG_DIRECTION: direction_d = item.write_data[PIN_W-1:0] & PinMask;
					REG_ENABLE:    enable_d    = item.write_data & IntMask;
					REG_RAW:       raw_w       = raw_q & ~item.write_data;
					REG_POLARITY:  polarity_d  = item.write_data & IntMask;
					REG_TYPE:      type_d      = item.write_data & IntMask;
					default:       ;
				endcase
			end
			FUNC_SAMPLE: sampled_d = item.pin_levels & PinMask;
			default:     ;
		endcase
	end

	assign value_d = ((output_d & direction_d) | (sampled_d & ~direction_d)) & PinMask;
	assign active  = ~(spread(value_d) ^ polarity_d) & IntMask;
	assign edges   = active & ~prev_active_q;
	assign raw_d   = ((raw_w | edges) & type_d) | (active & ~type_d & IntMask);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			output_q      <= '0;
			direction_q   <= '0;
			sampled_q     <= '0;
			enable_q      <= '0;
			raw_q         <= '0;
			polarity_q    <= '0;
			type_q        <= '0;
			prev_active_q <= '0;
		end else if (fire) begin
			output_q      <= output_d;
			direction_q   <= direction_d;
			sampled_q     <= sampled_d;
			enable_q      <= enable_d;
			raw_q         <= raw_d;
			polarity_q    <= polarity_d;
			type_q        <= type_d;
			prev_active_q <= active;
		end
	end

	assign result.read_data         = rdata;
	assign result.pin_drive         = output_d;
	assign result.pin_output_enable = direction_d;
	assign result.irq               = |(raw_d & enable_d);

endmodule

/* src/gpio_controller_with_interrupts.sv */
// GPIO controller with edge and level interrupts. Every request transaction
// is a register read, a register write or a pin sample tick; each one yields
// exactly one response transaction carrying the read word (zero for writes
// and ticks), the pin drive and output enable words and the irq flag, all as
// they stand after the transaction. One transaction is taken every cycle
// while req_stall is low; a request passes through the input register and
// then the response register, with the single-pass register and interrupt
// update in between. req_stall rises only while a response is held by
// rsp_stall and the input register is full.
`include "gpio_controller_with_interrupts_defines.svh"

module gpio_controller_with_interrupts
	import gpioc_pkg::*;
#(
	parameter int NUM_PINS = gpioc_pkg::NUM_PINS,
	parameter int LOW_PINS = gpioc_pkg::LOW_PINS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  gpio_in_t  req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output gpio_out_t rsp
);

	localparam logic [PIN_W-1:0] PinMask = PIN_W'((64'd1 << NUM_PINS) - 64'd1);

	logic      valid_s1;
	gpio_in_t  req_s1;
	logic      rsp_valid_q;
	gpio_out_t rsp_q;
	gpio_out_t core_result;
	logic      advance;
	logic      fire;

	assign advance   = !rsp_valid_q || !rsp_stall;
	assign fire      = valid_s1 && advance;
	assign req_stall = valid_s1 && !advance;

	gpioc_core #(
		.NUM_PINS(NUM_PINS),
		.LOW_PINS(LOW_PINS)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (fire),
		.item  (req_s1),
		.result(core_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (!req_stall) begin
				valid_s1 <= req_valid;
			end
			if (advance) begin
				rsp_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			req_s1 <= req;
		end
		if (fire) begin
			rsp_q <= core_result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`GPIOC_ASSERT_NEXT(a_fire_gives_rsp, fire, rsp_valid, "issued transaction lost its response")
	`GPIOC_ASSERT(a_stall_only_when_held, !req_stall || (rsp_valid && rsp_stall),
		"request stalled without a held response")
	`GPIOC_ASSERT(a_pins_in_range,
		!rsp_valid || (((rsp.pin_drive | rsp.pin_output_enable) & ~PinMask) == '0),
		"pin bits set above the pin count")

endmodule
